// ----- sv/pett_pkg.sv -----
package pett_pkg;

  // action codes
  localparam logic [1:0] ACT_CREATE = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRE   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  localparam logic STS_OK   = 1'b0;
  localparam logic STS_FAIL = 1'b1;

  // fire beats reported per tick
  localparam int MAX_FIRES = 16;

  typedef struct packed {
    logic [7:0]  owner;
    logic [23:0] period;
    logic [23:0] remain;
    logic [16:0] reps;
  } slot_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] fired_id;
    logic [3:0] slot_index;
    logic       status;
    logic       last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_nop;
    logic stall;
    logic scan_done;
    logic out_can_load;
  } sts_t;

endpackage

// ----- sv/pett_if.sv -----
interface pett_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [7:0]         task_id;
  logic [23:0]        delay_value;
  logic signed [16:0] repeat_count;
  logic [15:0]        tick_amount;

  modport source (output valid, action, task_id, delay_value, repeat_count, tick_amount,
                  input ready);
  modport sink (input valid, action, task_id, delay_value, repeat_count, tick_amount,
                output ready);
endinterface

interface pett_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] fired_id;
  logic [3:0] slot_index;
  logic       status;
  logic       last;

  modport source (output valid, kind, fired_id, slot_index, status, last, input ready);
  modport sink (input valid, kind, fired_id, slot_index, status, last, output ready);
endinterface

// ----- sv/pett_ram.sv -----
module pett_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/pett_ctrl.sv -----
module pett_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pett_pkg::sts_t sts,
  output pett_pkg::cmd_t cmd
);
  import pett_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid && !sts.in_nop) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.step = !sts.stall;
        end
      end
      ST_FIN: begin
        cmd.finish = sts.out_can_load;
        if (sts.out_can_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/pett_dp.sv -----
module pett_dp #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_task_id,
  input  logic [23:0]        in_delay_value,
  input  logic signed [16:0] in_repeat_count,
  input  logic [15:0]        in_tick_amount,
  input  pett_pkg::cmd_t     cmd,
  output pett_pkg::sts_t     sts,
  output logic               out_valid,
  output pett_pkg::res_t     out_res,
  input  logic               out_ready
);
  import pett_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = $bits(slot_t);

  function automatic logic [3:0] idx4(input logic [IW-1:0] i);
    logic [IW+3:0] e;
    e = {4'b0000, i};
    return e[3:0];
  endfunction

  // captured item
  logic [1:0]  act_r;
  logic [7:0]  id_r;
  logic [23:0] dly_r;
  logic [16:0] reps_r;
  logic [15:0] tick_r;

  // scan pipeline
  logic [CW-1:0]    iss_r;
  logic             s1_v_r;
  logic [IW-1:0]    s1_idx_r;
  logic             vbit_r;
  logic [SLOTS-1:0] vld_r;
  logic [4:0]       nfire_r;

  // create/remove search
  logic          match_f_r, free_f_r;
  logic [IW-1:0] match_idx_r, free_idx_r;
  logic [23:0]   match_per_r;

  logic out_v_r;
  res_t out_res_r;

  logic [SW-1:0] rd_raw;
  slot_t         cur, wr_slot;
  logic          issue_done, live, fire, report, need_emit, can_load;
  logic [23:0]   dec_rem;
  logic [16:0]   cnt_n;
  logic          we_tick, we_fin, we, re;
  logic [IW-1:0] waddr, raddr;
  logic          fin_ok;
  logic [IW-1:0] fin_slot;
  res_t          fin_res, fire_res;

  pett_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_slot),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_raw)
  );

  always_comb begin
    // entries never written read as cleared
    cur        = vbit_r ? slot_t'(rd_raw) : '0;
    issue_done = (iss_r == CW'(SLOTS));
    live       = (cur.remain != 24'd0) && (cur.reps != 17'd0);
    dec_rem    = ({8'd0, tick_r} < cur.remain) ? (cur.remain - {8'd0, tick_r}) : 24'd0;
    fire       = (act_r == ACT_TICK) && live && (dec_rem == 24'd0);
    cnt_n      = cur.reps[16] ? cur.reps : (cur.reps - 17'd1);
    report     = (nfire_r < 5'(MAX_FIRES));
    need_emit  = s1_v_r && fire && report;
    can_load   = !out_v_r || out_ready;

    sts.in_nop       = (in_action == ACT_NOP);
    sts.stall        = need_emit && !can_load;
    sts.scan_done    = issue_done && !s1_v_r;
    sts.out_can_load = can_load;

    // finish of create/remove
    if (act_r == ACT_CREATE) begin
      fin_ok   = (id_r != 8'd0) && (match_f_r || free_f_r);
      fin_slot = match_f_r ? match_idx_r : free_idx_r;
    end else begin
      fin_ok   = match_f_r;
      fin_slot = match_idx_r;
    end

    we_tick = cmd.step && s1_v_r && (act_r == ACT_TICK) && live;
    we_fin  = cmd.finish && fin_ok && (act_r != ACT_TICK);
    we      = we_tick || we_fin;
    waddr   = we_fin ? fin_slot : s1_idx_r;
    re      = cmd.step && !issue_done;
    raddr   = iss_r[IW-1:0];

    if (we_fin) begin
      if (act_r == ACT_CREATE) begin
        wr_slot = '{owner: id_r, period: dly_r, remain: dly_r, reps: reps_r};
      end else begin
        wr_slot = '{owner: id_r, period: match_per_r, remain: 24'd0, reps: 17'd0};
      end
    end else if (fire) begin
      wr_slot = '{owner: cur.owner, period: cur.period,
                  remain: (cnt_n != 17'd0) ? cur.period : 24'd0, reps: cnt_n};
    end else begin
      wr_slot = '{owner: cur.owner, period: cur.period, remain: dec_rem, reps: cur.reps};
    end

    fire_res = '{kind: KIND_FIRE, fired_id: cur.owner, slot_index: idx4(s1_idx_r),
                 status: STS_OK, last: 1'b0};
    if (act_r == ACT_TICK) begin
      fin_res = '{kind: KIND_END, fired_id: 8'd0, slot_index: 4'd0,
                  status: STS_OK, last: 1'b1};
    end else begin
      fin_res = '{kind: KIND_STATUS, fired_id: id_r,
                  slot_index: fin_ok ? idx4(fin_slot) : 4'd0,
                  status: fin_ok ? STS_OK : STS_FAIL, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act_r  <= in_action;
      id_r   <= in_task_id;
      dly_r  <= in_delay_value;
      reps_r <= in_repeat_count;
      tick_r <= in_tick_amount;
    end
    if (re) begin
      s1_idx_r <= raddr;
      vbit_r   <= vld_r[raddr];
    end
    if (cmd.step && s1_v_r) begin
      if ((id_r != 8'd0) && (cur.owner == id_r) && !match_f_r) begin
        match_idx_r <= s1_idx_r;
        match_per_r <= cur.period;
      end
      if ((cur.remain == 24'd0) && !free_f_r) begin
        free_idx_r <= s1_idx_r;
      end
    end
    if (cmd.step && need_emit) begin
      out_res_r <= fire_res;
    end else if (cmd.finish) begin
      out_res_r <= fin_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r     <= '0;
      s1_v_r    <= 1'b0;
      vld_r     <= '0;
      nfire_r   <= '0;
      match_f_r <= 1'b0;
      free_f_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (cmd.start) begin
        iss_r     <= '0;
        s1_v_r    <= 1'b0;
        nfire_r   <= '0;
        match_f_r <= 1'b0;
        free_f_r  <= 1'b0;
      end
      if (cmd.step) begin
        s1_v_r <= !issue_done;
        if (!issue_done) begin
          iss_r <= iss_r + CW'(1);
        end
        if (s1_v_r) begin
          if ((id_r != 8'd0) && (cur.owner == id_r)) begin
            match_f_r <= 1'b1;
          end
          if (cur.remain == 24'd0) begin
            free_f_r <= 1'b1;
          end
          if (fire && report) begin
            nfire_r <= nfire_r + 5'd1;
          end
        end
      end
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if ((cmd.step && need_emit) || cmd.finish) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_res_r;

endmodule

// ----- sv/periodic_event_timer_table_unit.sv -----
// Periodic timer table: SLOTS slots of {owner id, period, remaining delay,
// repeat count} held in one RAM, all cleared at reset through per-slot valid
// bits (no clearing pass). Every create, remove or tick walks the slots from
// index 0 upward, one slot per cycle through the RAM's single read port;
// a create/remove ends with one status beat, a tick emits one fire beat per
// expiring slot (at most 16, later ones still update silently) and then an
// end-of-tick beat with last set. The next item is taken only once the walk
// and its closing beat are done, later still while the result side holds off
// beats: a pending fire beat stalls the scan, and the closing beat waits for
// the output register to empty; action code 3 is dropped with no beats.
module periodic_event_timer_table_unit #(
  parameter int SLOTS = 16
) (
  input logic          clk,
  input logic          rst_n,
  pett_in_if.sink      in_ch,
  pett_out_if.source   out_ch
);
  import pett_pkg::*;

  cmd_t cmd;   // controller commands
  sts_t sts;   // datapath status
  res_t res;   // output beat payload

  pett_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pett_dp #(.SLOTS(SLOTS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_ch.action),
    .in_task_id      (in_ch.task_id),
    .in_delay_value  (in_ch.delay_value),
    .in_repeat_count (in_ch.repeat_count),
    .in_tick_amount  (in_ch.tick_amount),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_ch.valid),
    .out_res         (res),
    .out_ready       (out_ch.ready)
  );

  assign out_ch.kind       = res.kind;
  assign out_ch.fired_id   = res.fired_id;
  assign out_ch.slot_index = res.slot_index;
  assign out_ch.status     = res.status;
  assign out_ch.last       = res.last;

endmodule

// ----- dv/pett_timer_checker.sv -----
`timescale 1ns / 1ps

module pett_timer_checker #(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst_n,
  pett_in_if   in_ch,
  pett_out_if  out_ch,
  output int   n_errors,
  output int   n_waiting
);
  import pett_pkg::*;

  // shadow copy of the timer table
  logic [7:0]  owner_q  [SLOTS];
  logic [23:0] period_q [SLOTS];
  logic [23:0] remain_q [SLOTS];
  logic [16:0] repeat_q [SLOTS];

  res_t        due_beats[$];
  int          err_count = 0;

  assign n_errors = err_count;

  function automatic res_t mk_beat(logic [1:0] kind, logic [7:0] id, logic [3:0] idx,
                                   logic sts, logic lst);
    res_t b;
    b.kind       = kind;
    b.fired_id   = id;
    b.slot_index = idx;
    b.status     = sts;
    b.last       = lst;
    return b;
  endfunction

  // owner lookup: id 0 never matches
  function automatic int find_slot(logic [7:0] id);
    if (id == '0) return -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (owner_q[i] == id) return i;
    end
    return -1;
  endfunction

  task automatic apply_timer_action(input logic [1:0] act, input logic [7:0] id,
                                    input logic [23:0] dly, input logic [16:0] reps,
                                    input logic [15:0] amt);
    int          hit;
    int          fires;
    logic [23:0] rem;
    logic [16:0] cnt;
    hit   = -1;
    fires = 0;
    case (act)
      ACT_CREATE: begin
        if (id != '0) begin
          hit = find_slot(id);
          for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && remain_q[i] == '0) hit = i;
          end
        end
        if (hit < 0) begin
          due_beats.push_back(mk_beat(KIND_STATUS, id, '0, STS_FAIL, 1'b1));
        end else begin
          owner_q[hit]  = id;
          period_q[hit] = dly;
          remain_q[hit] = dly;
          repeat_q[hit] = reps;
          due_beats.push_back(mk_beat(KIND_STATUS, id, hit[3:0], STS_OK, 1'b1));
        end
      end
      ACT_REMOVE: begin
        hit = find_slot(id);
        if (hit < 0) begin
          due_beats.push_back(mk_beat(KIND_STATUS, id, '0, STS_FAIL, 1'b1));
        end else begin
          remain_q[hit] = '0;
          repeat_q[hit] = '0;
          due_beats.push_back(mk_beat(KIND_STATUS, id, hit[3:0], STS_OK, 1'b1));
        end
      end
      ACT_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          rem = remain_q[i];
          cnt = repeat_q[i];
          if (rem != '0 && cnt != '0) begin
            rem         = ({8'd0, amt} < rem) ? rem - amt : '0;
            remain_q[i] = rem;
            if (rem == '0) begin
              // negative count runs forever
              if (!cnt[16]) cnt = cnt - 1'b1;
              repeat_q[i] = cnt;
              if (cnt != '0) remain_q[i] = period_q[i];
              if (fires < MAX_FIRES) begin
                due_beats.push_back(mk_beat(KIND_FIRE, owner_q[i], i[3:0], STS_OK, 1'b0));
                fires++;
              end
            end
          end
        end
        due_beats.push_back(mk_beat(KIND_END, '0, '0, STS_OK, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic cmp_field(input string fname, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        owner_q[i]  = '0;
        period_q[i] = '0;
        remain_q[i] = '0;
        repeat_q[i] = '0;
      end
      due_beats.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        apply_timer_action(in_ch.action, in_ch.task_id, in_ch.delay_value,
                           in_ch.repeat_count, in_ch.tick_amount);
      if (out_ch.valid && out_ch.ready) begin
        if (due_beats.size() == 0) begin
          $error("unexpected beat: kind %0d id %0d slot %0d", out_ch.kind, out_ch.fired_id,
                 out_ch.slot_index);
          err_count++;
        end else begin
          want = due_beats.pop_front();
          cmp_field("kind", want.kind, out_ch.kind);
          cmp_field("fired_id", want.fired_id, out_ch.fired_id);
          cmp_field("slot_index", want.slot_index, out_ch.slot_index);
          cmp_field("status", want.status, out_ch.status);
          cmp_field("last", want.last, out_ch.last);
        end
      end
    end
    n_waiting <= due_beats.size();
  end

endmodule

// ----- dv/tb_periodic_event_timer_table_unit.sv -----
`timescale 1ns / 1ps

module tb_periodic_event_timer_table_unit;
  import pett_pkg::*;

  localparam int N_SLOTS    = 16;
  localparam int N_ITEMS    = 330;
  localparam int CALM_AFTER = 280;   // no idling from here on
  localparam int HOLD_LEN   = 400;   // long receiver hold-off
  localparam int TAIL_WAIT  = 40;    // > one scan of the table
  // Cycles without any beat before we give up. Worst legal quiet stretch is
  // the long hold-off plus a sender gap plus one table scan, well below this.
  localparam int QUIET_MAX  = 2000;

  logic clk = 1'b0;
  logic rst_n;

  pett_in_if  in_ch ();
  pett_out_if out_ch ();

  int   n_errors;
  int   n_waiting;
  int   sent;
  int   quiet = 0;
  logic calm;
  logic hold_req;
  logic hold_done;

  periodic_event_timer_table_unit #(
    .SLOTS (N_SLOTS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pett_timer_checker #(
    .SLOTS (N_SLOTS)
  ) i_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .n_errors  (n_errors),
    .n_waiting (n_waiting)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: quiet cycles reset on any beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_MAX) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Random repeat count: mostly small finite, some forever, some zero, some
  // anything (covers the sign bit and the upper bits).
  function automatic logic [16:0] pick_reps();
    case ($urandom_range(0, 5))
      0:       return 17'h1FFFF;
      1:       return '0;
      2:       return 17'($urandom);
      default: return 17'($urandom_range(1, 4));
    endcase
  endfunction

  // One input beat. Optional gap first; valid stays high across back to back
  // beats, so it is never lowered and raised in the same step.
  task automatic send_beat(input logic [1:0] act, input logic [7:0] id,
                           input logic [23:0] dly, input logic [16:0] reps,
                           input logic [15:0] amt);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.task_id      <= id;
    in_ch.delay_value  <= dly;
    in_ch.repeat_count <= reps;
    in_ch.tick_amount  <= amt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (act != ACT_NOP) sent++;
    if (sent >= CALM_AFTER) calm = 1'b1;
  endtask

  // Result side: random ready bursts, plus one long hold-off once the first
  // table fill starts, so the block backs up and stalls its input.
  initial begin
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    int          seq;
    logic [1:0]  act;
    logic [7:0]  id;
    logic [23:0] dly;
    logic [15:0] amt;

    rst_n              = 1'b0;
    calm               = 1'b0;
    hold_req           = 1'b0;
    sent               = 0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_NOP;
    in_ch.task_id      = '0;
    in_ch.delay_value  = '0;
    in_ch.repeat_count = '0;
    in_ch.tick_amount  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    send_beat(ACT_CREATE, 8'd0,   24'd5,        17'd1,      16'd0);      // id zero rejected
    send_beat(ACT_REMOVE, 8'd0,   24'd0,        17'd0,      16'd0);      // id zero rejected
    send_beat(ACT_REMOVE, 8'd77,  24'd0,        17'd0,      16'd0);      // unknown id
    send_beat(ACT_TICK,   8'd0,   24'd0,        17'd0,      16'd10);     // empty table
    send_beat(ACT_CREATE, 8'd1,   24'd1,        17'd1,      16'd0);      // one-shot
    send_beat(ACT_CREATE, 8'd255, 24'hFFFFFF,   17'h1FFFF,  16'hFFFF);   // max delay, forever
    send_beat(ACT_CREATE, 8'd2,   24'd3,        17'd0,      16'd0);      // occupied, never fires
    send_beat(ACT_CREATE, 8'd3,   24'd5,        17'd65535,  16'd0);      // max count
    send_beat(ACT_CREATE, 8'd4,   24'd2,        17'h10000,  16'd0);      // most negative: forever
    send_beat(ACT_CREATE, 8'd5,   24'd0,        17'd3,      16'd0);      // zero delay: inactive
    send_beat(ACT_TICK,   8'd9,   24'd7,        17'd2,      16'd0);      // zero tick: no fires
    send_beat(ACT_TICK,   8'd0,   24'd0,        17'd0,      16'd1);      // one-shot expires
    send_beat(ACT_NOP,    8'hA5,  24'h5A5A5A,   17'h0F0F0,  16'h1234);   // dropped, no beats
    send_beat(ACT_TICK,   8'd0,   24'd0,        17'd0,      16'hFFFF);   // big tick, reloads
    send_beat(ACT_CREATE, 8'd3,   24'd10,       17'd2,      16'd0);      // update same owner
    send_beat(ACT_REMOVE, 8'd3,   24'd0,        17'd0,      16'd0);
    send_beat(ACT_REMOVE, 8'd3,   24'd0,        17'd0,      16'd0);      // owner kept after remove
    send_beat(ACT_CREATE, 8'd6,   24'd7,        17'd1,      16'd0);      // reuses a free slot
    send_beat(ACT_REMOVE, 8'd2,   24'd0,        17'd0,      16'd0);
    send_beat(ACT_TICK,   8'd0,   24'd0,        17'd0,      16'hFFFF);

    // ---- random part ----
    seq = 0;
    while (sent < N_ITEMS) begin
      case ((seq == 0) ? 0 : $urandom_range(0, 9))
        0: begin
          // Fill the table with short forever/short-count timers, overflow it,
          // then fire the live ones in one tick (up to sixteen fire beats).
          hold_req <= 1'b1;
          for (int k = 1; k <= N_SLOTS; k++)
            send_beat(ACT_CREATE, 8'(k), 24'($urandom_range(1, 4)),
                      ($urandom_range(0, 1) == 0) ? 17'h1FFFF : pick_reps(), 16'($urandom));
          send_beat(ACT_CREATE, 8'($urandom_range(100, 255)), 24'($urandom_range(1, 50)),
                    pick_reps(), 16'($urandom));
          send_beat(ACT_TICK, 8'($urandom), 24'($urandom), 17'($urandom), 16'hFFFF);
          if ($urandom_range(0, 1) == 0) begin
            for (int k = 1; k <= N_SLOTS; k++)
              send_beat(ACT_REMOVE, 8'(k), 24'($urandom), 17'($urandom), 16'($urandom));
          end
        end
        1, 2: begin
          // noise: every field fully random, unused action code included
          repeat (5)
            send_beat(2'($urandom_range(0, 3)), 8'($urandom), 24'($urandom), 17'($urandom),
                      16'($urandom));
        end
        default: begin
          // well-formed traffic on a small id pool so slots get reused
          repeat (10) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3: act = ACT_CREATE;
              4, 5:       act = ACT_REMOVE;
              default:    act = ACT_TICK;
            endcase
            id  = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 16));
            case ($urandom_range(0, 9))
              0:       dly = '0;
              1:       dly = 24'($urandom);
              default: dly = 24'($urandom_range(1, 12));
            endcase
            amt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
            send_beat(act, id, dly, pick_reps(), amt);
          end
        end
      endcase
      seq++;
    end
    in_ch.valid <= 1'b0;

    // drain: expectations first, then a table scan's worth of quiet
    @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (n_errors == 0 && n_waiting == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
